@@ sv/gppb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gppb_pkg: shared types and constants for the grid point projection block
// Field widths, register codes and the fixed-point layout of the datapath.
// ----------------------------------------------------------------------------
package gppb_pkg;

	localparam int GRID_INDEX_BITS = 10;
	localparam int OUT_BITS        = 24;
	localparam int COEF_BITS       = 16;
	localparam int ZOOM_BITS       = 24;
	localparam int HSCALE_BITS     = 16;
	localparam int HEIGHT_BITS     = 16;
	localparam int CFG_DATA_BITS   = 24;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int QUEUE_DEPTH     = 4;

	// Datapath layout.
	localparam int HPROD_BITS   = HSCALE_BITS + HEIGHT_BITS;
	localparam int HEIGHT_SHIFT = 8;                       // Q8.8 height factor
	localparam int ZS_BITS      = 24;                      // scaled height, |zs| <= 2^22
	localparam int SUM_BITS     = 40;                      // matrix sums, |s| < 2^38
	localparam int ZOOM_SPLIT   = 12;                      // zoom multiply in two halves
	localparam int PART_BITS    = SUM_BITS + ZOOM_SPLIT + 1;
	localparam int PROD_BITS    = 64;
	localparam int FRAC_SHIFT   = 26;                      // Q.14 times Q12.12

	localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_COEF_XX      = 3'd0,
		REG_COEF_YX      = 3'd1,
		REG_COEF_ZX      = 3'd2,
		REG_COEF_XY      = 3'd3,
		REG_COEF_YY      = 3'd4,
		REG_COEF_ZY      = 3'd5,
		REG_ZOOM_FACTOR  = 3'd6,
		REG_HEIGHT_SCALE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [GRID_INDEX_BITS-1:0] col_index;
		logic [GRID_INDEX_BITS-1:0] row_index;
		logic signed [HEIGHT_BITS-1:0] height;
		logic first_point;
	} point_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] proj_x;
		logic signed [OUT_BITS-1:0] proj_y;
		logic signed [OUT_BITS-1:0] min_x;
		logic signed [OUT_BITS-1:0] max_x;
		logic signed [OUT_BITS-1:0] min_y;
		logic signed [OUT_BITS-1:0] max_y;
	} result_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] coef_xx;
		logic signed [COEF_BITS-1:0] coef_yx;
		logic signed [COEF_BITS-1:0] coef_zx;
		logic signed [COEF_BITS-1:0] coef_xy;
		logic signed [COEF_BITS-1:0] coef_yy;
		logic signed [COEF_BITS-1:0] coef_zy;
		logic [ZOOM_BITS-1:0] zoom_factor;
		logic signed [HSCALE_BITS-1:0] height_scale;
	} cfg_regs_t;

	// Projected point handed from the front pipeline to the bounds unit.
	typedef struct packed {
		logic first_point;
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
	} proj_t;

	// Queue handshake seen by the front pipeline.
	typedef struct packed {
		logic push;
	} queue_ctl_t;

endpackage
`default_nettype wire

@@ sv/grid_point_projection_bounds.sv @@
`default_nettype none
// Path: a point runs through the 7 projection stages, the queue and the
//   bounds merge before its result reaches the output register.
// Throughput: one point per cycle while results are taken, set by the
//   pipelined datapath and bounds merge; a held result backs up into the queue.
// Reset: arst_n clears all valid state, loads the default coefficients and
//   sets the bounds to their empty values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// grid_point_projection_bounds: height-map point projection with bounds
// Projects column, row and scaled height through a 2x3 Q2.14 matrix and a
// Q12.12 zoom, and keeps the running minimum and maximum of the results.
// ----------------------------------------------------------------------------
module grid_point_projection_bounds #(
	parameter int QUEUE_DEPTH = gppb_pkg::QUEUE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port: write only while the block is idle; not enforced.
	input  wire logic                                 cfg_we,
	input  wire logic [gppb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [gppb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// Point input channel.
	input  wire logic                                 point_valid,
	output logic                                      point_stall,
	input  gppb_pkg::point_t                          point,
	// Result output channel.
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output gppb_pkg::result_t                         result
);
	import gppb_pkg::*;

	cfg_regs_t  cfg_q;
	queue_ctl_t qctl;
	proj_t      push_data;
	proj_t      head;
	logic       queue_full;
	logic       head_valid;
	logic       pop;

	// Register file. Every three-bit index names a register, so each write
	// lands somewhere; the coefficients keep only their low sixteen bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx      <= 16'sd16384;
			cfg_q.coef_yx      <= -16'sd6951;
			cfg_q.coef_zx      <= 16'sd0;
			cfg_q.coef_xy      <= 16'sd0;
			cfg_q.coef_yy      <= 16'sd6951;
			cfg_q.coef_zy      <= 16'sd16384;
			cfg_q.zoom_factor  <= 24'd4096;
			cfg_q.height_scale <= 16'sd256;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_XX:      cfg_q.coef_xx      <= cfg_data[COEF_BITS-1:0];
				REG_COEF_YX:      cfg_q.coef_yx      <= cfg_data[COEF_BITS-1:0];
				REG_COEF_ZX:      cfg_q.coef_zx      <= cfg_data[COEF_BITS-1:0];
				REG_COEF_XY:      cfg_q.coef_xy      <= cfg_data[COEF_BITS-1:0];
				REG_COEF_YY:      cfg_q.coef_yy      <= cfg_data[COEF_BITS-1:0];
				REG_COEF_ZY:      cfg_q.coef_zy      <= cfg_data[COEF_BITS-1:0];
				REG_ZOOM_FACTOR:  cfg_q.zoom_factor  <= cfg_data[ZOOM_BITS-1:0];
				REG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_data[HSCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Front: takes points and runs the projection arithmetic. It stalls the
	// input only when its last stage holds a point and the queue is full.
	gppb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.qctl        (qctl),
		.queue_full  (queue_full),
		.push_data   (push_data)
	);

	// The queue lets the front keep going while a result waits downstream.
	gppb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl      (qctl),
		.push_data (push_data),
		.full      (queue_full),
		.not_empty (head_valid),
		.pop       (pop),
		.head      (head)
	);

	// Back: bounds merge and output register. A new point is popped whenever
	// the output register is empty or its result is transferred this cycle.
	gppb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

@@ sv/gppb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gppb_front: projection pipeline
// Seven stages: height scaling, matrix products, sums, split zoom multiply,
// and truncation with saturation. The whole pipeline holds while its last
// stage cannot enter the queue.
// ----------------------------------------------------------------------------
module gppb_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  gppb_pkg::cfg_regs_t     cfg,
	input  wire logic               point_valid,
	output logic                    point_stall,
	input  gppb_pkg::point_t        point,
	output gppb_pkg::queue_ctl_t    qctl,
	input  wire logic               queue_full,
	output gppb_pkg::proj_t         push_data
);
	import gppb_pkg::*;

	localparam int CP_BITS = GRID_INDEX_BITS + COEF_BITS + 1;
	localparam int ZP_BITS = ZS_BITS + COEF_BITS;

	function automatic logic signed [OUT_BITS-1:0] trunc_sat(
		input logic signed [PROD_BITS-1:0] p
	);
		logic signed [PROD_BITS-1:0] biased;
		logic signed [PROD_BITS-1:0] q;
		biased = p + (p[PROD_BITS-1] ?
			PROD_BITS'((64'sd1 <<< FRAC_SHIFT) - 64'sd1) : PROD_BITS'(0));
		q = biased >>> FRAC_SHIFT;
		if (q > PROD_BITS'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (q < PROD_BITS'(OUT_MIN)) begin
			return OUT_MIN;
		end else begin
			return OUT_BITS'(q);
		end
	endfunction

	logic adv;
	logic [6:0] valid_q;

	// Stage payloads.
	logic [GRID_INDEX_BITS-1:0] col_s1, row_s1, col_s2, row_s2;
	logic first_s1, first_s2, first_s3, first_s4, first_s5, first_s6, first_s7;
	logic signed [HPROD_BITS-1:0] hprod_s1;
	logic signed [ZS_BITS-1:0] zs_s2;
	logic signed [CP_BITS-1:0] cxx_s3, ryx_s3, cxy_s3, ryy_s3;
	logic signed [ZP_BITS-1:0] zzx_s3, zzy_s3;
	logic signed [SUM_BITS-1:0] sx_s4, sy_s4;
	logic signed [PART_BITS-1:0] xlo_s5, xhi_s5, ylo_s5, yhi_s5;
	logic signed [PROD_BITS-1:0] px_s6, py_s6;
	logic signed [OUT_BITS-1:0] px_s7, py_s7;

	// Scaled height, truncated toward zero.
	logic signed [HPROD_BITS:0] neg_prod, neg_biased;
	logic signed [GRID_INDEX_BITS:0] col_ext, row_ext;

	always_comb begin
		neg_prod   = -((HPROD_BITS+1)'(hprod_s1));
		neg_biased = neg_prod + (neg_prod[HPROD_BITS] ?
			(HPROD_BITS+1)'((1 << HEIGHT_SHIFT) - 1) : (HPROD_BITS+1)'(0));
		col_ext    = $signed({1'b0, col_s2});
		row_ext    = $signed({1'b0, row_s2});
	end

	assign adv         = !(valid_q[6] && queue_full);
	assign point_stall = !adv;
	assign qctl.push   = valid_q[6] && adv;
	assign push_data   = '{first_point: first_s7, px: px_s7, py: py_s7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[5:0], point_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1   <= point.col_index;
			row_s1   <= point.row_index;
			first_s1 <= point.first_point;
			hprod_s1 <= HPROD_BITS'($signed(cfg.height_scale) * $signed(point.height));

			col_s2   <= col_s1;
			row_s2   <= row_s1;
			first_s2 <= first_s1;
			zs_s2    <= ZS_BITS'(neg_biased >>> HEIGHT_SHIFT);

			first_s3 <= first_s2;
			cxx_s3   <= CP_BITS'(col_ext * $signed(cfg.coef_xx));
			ryx_s3   <= CP_BITS'(row_ext * $signed(cfg.coef_yx));
			zzx_s3   <= ZP_BITS'(zs_s2 * $signed(cfg.coef_zx));
			cxy_s3   <= CP_BITS'(col_ext * $signed(cfg.coef_xy));
			ryy_s3   <= CP_BITS'(row_ext * $signed(cfg.coef_yy));
			zzy_s3   <= ZP_BITS'(zs_s2 * $signed(cfg.coef_zy));

			first_s4 <= first_s3;
			sx_s4    <= SUM_BITS'(cxx_s3) + SUM_BITS'(ryx_s3) + SUM_BITS'(zzx_s3);
			sy_s4    <= SUM_BITS'(cxy_s3) + SUM_BITS'(ryy_s3) + SUM_BITS'(zzy_s3);

			// Zoom is unsigned; each half enters as a positive signed operand.
			first_s5 <= first_s4;
			xlo_s5   <= PART_BITS'(sx_s4 *
				$signed({1'b0, cfg.zoom_factor[ZOOM_SPLIT-1:0]}));
			xhi_s5   <= PART_BITS'(sx_s4 *
				$signed({1'b0, cfg.zoom_factor[ZOOM_BITS-1:ZOOM_SPLIT]}));
			ylo_s5   <= PART_BITS'(sy_s4 *
				$signed({1'b0, cfg.zoom_factor[ZOOM_SPLIT-1:0]}));
			yhi_s5   <= PART_BITS'(sy_s4 *
				$signed({1'b0, cfg.zoom_factor[ZOOM_BITS-1:ZOOM_SPLIT]}));

			first_s6 <= first_s5;
			px_s6    <= (PROD_BITS'(xhi_s5) <<< ZOOM_SPLIT) + PROD_BITS'(xlo_s5);
			py_s6    <= (PROD_BITS'(yhi_s5) <<< ZOOM_SPLIT) + PROD_BITS'(ylo_s5);

			first_s7 <= first_s6;
			px_s7    <= trunc_sat(px_s6);
			py_s7    <= trunc_sat(py_s6);
		end
	end

endmodule
`default_nettype wire

@@ sv/gppb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gppb_queue: short queue between projection pipeline and bounds unit
// Circular buffer of projected points with a fill count.
// ----------------------------------------------------------------------------
module gppb_queue #(
	parameter int DEPTH = gppb_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  gppb_pkg::queue_ctl_t qctl,
	input  gppb_pkg::proj_t      push_data,
	output logic                 full,
	output logic                 not_empty,
	input  wire logic            pop,
	output gppb_pkg::proj_t      head
);
	import gppb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	proj_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qctl.push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (qctl.push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !qctl.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ sv/gppb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gppb_back: running bounds and result register
// Merges each projected point into the bounds and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module gppb_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  gppb_pkg::proj_t  head,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output gppb_pkg::result_t result
);
	import gppb_pkg::*;

	logic signed [OUT_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [OUT_BITS-1:0] min_x_n, max_x_n, min_y_n, max_y_n;
	logic take;

	assign take = result_valid && !result_stall;
	assign pop  = head_valid && (!result_valid || take);

	always_comb begin
		if (head.first_point) begin
			min_x_n = head.px;
			max_x_n = head.px;
			min_y_n = head.py;
			max_y_n = head.py;
		end else begin
			min_x_n = (head.px < min_x_q) ? head.px : min_x_q;
			max_x_n = (head.px > max_x_q) ? head.px : max_x_q;
			min_y_n = (head.py < min_y_q) ? head.py : min_y_q;
			max_y_n = (head.py > max_y_q) ? head.py : max_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			min_x_q      <= OUT_MAX;
			max_x_q      <= OUT_MIN;
			min_y_q      <= OUT_MAX;
			max_y_q      <= OUT_MIN;
		end else if (pop) begin
			result_valid <= 1'b1;
			min_x_q      <= min_x_n;
			max_x_q      <= max_x_n;
			min_y_q      <= min_y_n;
			max_y_q      <= max_y_n;
		end else if (take) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result <= '{proj_x: head.px, proj_y: head.py,
				min_x: min_x_n, max_x: max_x_n, min_y: min_y_n, max_y: max_y_n};
		end
	end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_point_projection_bounds
// Streams height-map points through the projection block and checks every
// result word against an in-bench projection with its own running bounds, or
// hand-worked values. A directed list covers extremes, saturation,
// truncation and the bounds restart. Random phases follow, each under new
// register settings; sender and receiver idling change every two phases.
// ----------------------------------------------------------------------------
module tb;
	import gppb_pkg::*;

	localparam int LATENCY       = 8;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int RAND_PHASES   = 6;
	localparam int PHASE_POINTS  = 190;
	localparam int HOLD_CYCLES   = 64;

	// One line of the directed list is either a point or a register write.
	typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		cfg_reg_t                  reg_idx;
		logic [CFG_DATA_BITS-1:0]  data;
		point_t                    pt;
		bit                        typed;
		result_t                   res;
	} row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0]   cfg_data;
	logic                       point_valid;
	logic                       point_stall;
	point_t                     point_in;
	logic                       result_valid;
	logic                       result_stall;
	result_t                    result_out;

	// Register settings and running bounds as the bench believes them to be.
	cfg_regs_t                  cfg_model;
	logic signed [OUT_BITS-1:0] lo_x, hi_x, lo_y, hi_y;

	// Projected results owed by the block, oldest first.
	result_t                    projected_q[$];
	result_t                    owed;

	row_t                       dir_rows[$];

	// Idle percentages for the two sides, changed phase by phase.
	int                         send_idle_pct;
	int                         recv_idle_pct;

	// Shadow copies of driven levels, so that a level is never lowered twice
	// in the same time step.
	bit                         offering;
	bit                         cfg_we_high;

	// Long receiver hold-off, requested by the stimulus and timed by the
	// receiver process itself.
	logic                       hold_req;
	bit                         hold_done;
	int                         hold_left;

	int                         mismatch_cnt;
	int                         points_sent;
	int                         results_seen;
	int                         sat_cnt;
	int                         stall_cycles;
	int                         restarts;
	int                         cycle_cnt;

	grid_point_projection_bounds u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_out)
	);

	always #10 clk = ~clk;

	// Clamp a projected coordinate to the signed output range.
	function automatic logic signed [OUT_BITS-1:0] saturate_out(input longint q);
		if (q > longint'(OUT_MAX))
			return OUT_MAX;
		if (q < longint'(OUT_MIN))
			return OUT_MIN;
		return q[OUT_BITS-1:0];
	endfunction

	// Project one point with the current settings and fold it into the
	// running bounds. The scaled height and the final division both truncate
	// toward zero, which is what integer division does on longint.
	function automatic result_t project_point(input point_t p);
		longint col, row, zs, sx, sy, zoom;
		logic signed [OUT_BITS-1:0] px, py;
		result_t r;
		col  = longint'(p.col_index);
		row  = longint'(p.row_index);
		zoom = longint'(cfg_model.zoom_factor);
		zs   = -(longint'($signed(cfg_model.height_scale)) * longint'($signed(p.height)))
			/ 256;
		sx = col * longint'($signed(cfg_model.coef_xx))
			+ row * longint'($signed(cfg_model.coef_yx))
			+ zs * longint'($signed(cfg_model.coef_zx));
		sy = col * longint'($signed(cfg_model.coef_xy))
			+ row * longint'($signed(cfg_model.coef_yy))
			+ zs * longint'($signed(cfg_model.coef_zy));
		px = saturate_out(sx * zoom / (longint'(1) << FRAC_SHIFT));
		py = saturate_out(sy * zoom / (longint'(1) << FRAC_SHIFT));
		if (px == OUT_MAX || px == OUT_MIN || py == OUT_MAX || py == OUT_MIN)
			sat_cnt++;
		if (p.first_point) begin
			lo_x = px;
			hi_x = px;
			lo_y = py;
			hi_y = py;
			restarts++;
		end else begin
			if (px < lo_x) lo_x = px;
			if (px > hi_x) hi_x = px;
			if (py < lo_y) lo_y = py;
			if (py > hi_y) hi_y = py;
		end
		r.proj_x = px;
		r.proj_y = py;
		r.min_x  = lo_x;
		r.max_x  = hi_x;
		r.min_y  = lo_y;
		r.max_y  = hi_y;
		return r;
	endfunction

	function automatic row_t pt_row(input int c, input int r, input int h, input bit f);
		row_t x;
		x.kind           = ROW_POINT;
		x.reg_idx        = REG_COEF_XX;
		x.data           = '0;
		x.pt.col_index   = c[GRID_INDEX_BITS-1:0];
		x.pt.row_index   = r[GRID_INDEX_BITS-1:0];
		x.pt.height      = h[HEIGHT_BITS-1:0];
		x.pt.first_point = f;
		x.typed          = 1'b0;
		x.res            = '0;
		return x;
	endfunction

	// A point whose whole result can be read off by hand.
	function automatic row_t typed_row(input int c, input int r, input int h, input bit f,
			input int px, input int py, input int mnx, input int mxx,
			input int mny, input int mxy);
		row_t x;
		x            = pt_row(c, r, h, f);
		x.typed      = 1'b1;
		x.res.proj_x = px[OUT_BITS-1:0];
		x.res.proj_y = py[OUT_BITS-1:0];
		x.res.min_x  = mnx[OUT_BITS-1:0];
		x.res.max_x  = mxx[OUT_BITS-1:0];
		x.res.min_y  = mny[OUT_BITS-1:0];
		x.res.max_y  = mxy[OUT_BITS-1:0];
		return x;
	endfunction

	function automatic row_t write_row(input cfg_reg_t idx, input int v);
		row_t x;
		x         = pt_row(0, 0, 0, 1'b0);
		x.kind    = ROW_WRITE;
		x.reg_idx = idx;
		x.data    = v[CFG_DATA_BITS-1:0];
		return x;
	endfunction

	function automatic logic [GRID_INDEX_BITS-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return GRID_INDEX_BITS'($urandom_range(0, (1 << GRID_INDEX_BITS) - 1));
		endcase
	endfunction

	task automatic lower_valid();
		if (offering) begin
			point_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Offer one point, with a random idle gap in front of it, and hold it
	// until the block takes it. The owed result is queued at the transfer.
	task automatic send_point(input point_t p, input bit typed, input result_t typed_res);
		result_t r;
		if (cfg_we_high) begin
			cfg_we <= 1'b0;
			cfg_we_high = 1'b0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			lower_valid();
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_in    <= p;
		offering = 1'b1;
		@(posedge clk);
		while (point_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		r = project_point(p);
		projected_q.push_back(typed ? typed_res : r);
		points_sent++;
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic wait_drained();
		lower_valid();
		while (projected_q.size() != 0)
			@(posedge clk);
	endtask

	// One register write, only ever issued while the block is drained.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we_high = 1'b1;
		case (idx)
			REG_COEF_XX:      cfg_model.coef_xx      = data[COEF_BITS-1:0];
			REG_COEF_YX:      cfg_model.coef_yx      = data[COEF_BITS-1:0];
			REG_COEF_ZX:      cfg_model.coef_zx      = data[COEF_BITS-1:0];
			REG_COEF_XY:      cfg_model.coef_xy      = data[COEF_BITS-1:0];
			REG_COEF_YY:      cfg_model.coef_yy      = data[COEF_BITS-1:0];
			REG_COEF_ZY:      cfg_model.coef_zy      = data[COEF_BITS-1:0];
			REG_ZOOM_FACTOR:  cfg_model.zoom_factor  = data[ZOOM_BITS-1:0];
			REG_HEIGHT_SCALE: cfg_model.height_scale = data[HSCALE_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// New settings for every register. Extremes come up often; small zooms
	// and small height factors keep many points out of saturation. The unused
	// upper bits of the 16-bit registers carry noise.
	task automatic random_config();
		cfg_reg_t idx;
		logic [CFG_DATA_BITS-1:0] v;
		idx = idx.first();
		do begin
			case (idx)
				REG_ZOOM_FACTOR:
					case ($urandom_range(0, 4))
						0: v = '0;
						1: v = '1;
						2, 3: v = CFG_DATA_BITS'($urandom_range(0, 8192));
						default: v = CFG_DATA_BITS'($urandom);
					endcase
				REG_HEIGHT_SCALE:
					case ($urandom_range(0, 4))
						0: v = {8'($urandom), 16'h8000};
						1: v = {8'($urandom), 16'h7FFF};
						2, 3: v = {8'($urandom), 16'($urandom_range(0, 1024) - 512)};
						default: v = CFG_DATA_BITS'($urandom);
					endcase
				default:
					case ($urandom_range(0, 5))
						0: v = {8'($urandom), 16'h8000};
						1: v = {8'($urandom), 16'h7FFF};
						2: v = {8'($urandom), 16'h0000};
						default: v = CFG_DATA_BITS'($urandom);
					endcase
			endcase
			write_reg(idx, v);
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	task automatic check_field(input string name, input logic signed [OUT_BITS-1:0] want,
			input logic signed [OUT_BITS-1:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request so that
	// the pipeline and its queue fill up and the input stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (projected_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t ns: result with none owed, actual x %0d y %0d",
					$time, result_out.proj_x, result_out.proj_y);
			end else begin
				owed = projected_q.pop_front();
				check_field("proj_x", owed.proj_x, result_out.proj_x);
				check_field("proj_y", owed.proj_y, result_out.proj_y);
				check_field("min_x", owed.min_x, result_out.min_x);
				check_field("max_x", owed.max_x, result_out.max_x);
				check_field("min_y", owed.min_y, result_out.min_y);
				check_field("max_y", owed.max_y, result_out.max_y);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d results owed",
				cycle_cnt, projected_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		point_t p;
		row_t   row;

		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_COEF_XX;
		cfg_data     = '0;
		point_valid  = 1'b0;
		point_in     = '0;
		result_stall = 1'b0;
		hold_req     = 1'b0;
		hold_done    = 1'b0;
		hold_left    = 0;
		offering     = 1'b0;
		cfg_we_high  = 1'b0;
		mismatch_cnt = 0;
		points_sent  = 0;
		results_seen = 0;
		sat_cnt      = 0;
		stall_cycles = 0;
		restarts     = 0;
		cycle_cnt    = 0;

		// Sender idles a little, receiver a lot, for the directed list and
		// the first random phases.
		send_idle_pct = 13;
		recv_idle_pct = 60;

		// Settings and bounds as they stand after reset.
		cfg_model.coef_xx      = 16'sd16384;
		cfg_model.coef_yx      = -16'sd6951;
		cfg_model.coef_zx      = 16'sd0;
		cfg_model.coef_xy      = 16'sd0;
		cfg_model.coef_yy      = 16'sd6951;
		cfg_model.coef_zy      = 16'sd16384;
		cfg_model.zoom_factor  = 24'd4096;
		cfg_model.height_scale = 16'sd256;
		lo_x = OUT_MAX;
		hi_x = OUT_MIN;
		lo_y = OUT_MAX;
		hi_y = OUT_MIN;

		// Reset defaults: with no restart yet, the first point merges with
		// the empty bounds and becomes them. With zoom 1.0 and a unit height
		// factor, x is the column and y the negated height when row is 0.
		dir_rows.push_back(typed_row(0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(1023, 0, -32768, 1'b1,
			1023, 32768, 1023, 1023, 32768, 32768));
		dir_rows.push_back(typed_row(0, 0, 32767, 1'b0,
			0, -32767, 0, 1023, -32767, 32768));
		// A small negative x sum must truncate to zero, not to minus one.
		dir_rows.push_back(pt_row(0, 1, 0, 1'b0));
		dir_rows.push_back(pt_row(0, 1023, 0, 1'b0));
		dir_rows.push_back(pt_row(1023, 1023, -1, 1'b0));
		dir_rows.push_back(pt_row(682, 341, -21846, 1'b0));
		dir_rows.push_back(pt_row(341, 682, 21845, 1'b1));
		// Height factor of 1/256: the scaled height truncates toward zero
		// from both sides.
		dir_rows.push_back(write_row(REG_HEIGHT_SCALE, 1));
		dir_rows.push_back(pt_row(3, 3, 255, 1'b0));
		dir_rows.push_back(pt_row(3, 3, -255, 1'b0));
		// Extreme weights and zoom drive both coordinates into saturation,
		// one way and then the other.
		dir_rows.push_back(write_row(REG_COEF_ZX, 32767));
		dir_rows.push_back(write_row(REG_COEF_ZY, -32768));
		dir_rows.push_back(write_row(REG_HEIGHT_SCALE, -32768));
		dir_rows.push_back(write_row(REG_ZOOM_FACTOR, 16777215));
		dir_rows.push_back(typed_row(0, 0, -32768, 1'b1,
			OUT_MIN, OUT_MAX, OUT_MIN, OUT_MIN, OUT_MAX, OUT_MAX));
		dir_rows.push_back(typed_row(1023, 1023, 32767, 1'b0,
			OUT_MAX, OUT_MIN, OUT_MIN, OUT_MAX, OUT_MIN, OUT_MAX));
		// Zero zoom flattens everything; bounds keep their extremes until
		// the restart.
		dir_rows.push_back(write_row(REG_ZOOM_FACTOR, 0));
		dir_rows.push_back(typed_row(1023, 1023, -32768, 1'b0,
			0, 0, OUT_MIN, OUT_MAX, OUT_MIN, OUT_MAX));
		dir_rows.push_back(typed_row(5, 5, 5, 1'b1, 0, 0, 0, 0, 0, 0));
		// Every weight at an extreme, unit zoom.
		dir_rows.push_back(write_row(REG_COEF_XX, -32768));
		dir_rows.push_back(write_row(REG_COEF_YX, 32767));
		dir_rows.push_back(write_row(REG_COEF_XY, 32767));
		dir_rows.push_back(write_row(REG_COEF_YY, -32768));
		dir_rows.push_back(write_row(REG_COEF_ZX, -32768));
		dir_rows.push_back(write_row(REG_COEF_ZY, 32767));
		dir_rows.push_back(write_row(REG_ZOOM_FACTOR, 4096));
		dir_rows.push_back(write_row(REG_HEIGHT_SCALE, 256));
		dir_rows.push_back(pt_row(1023, 0, 0, 1'b1));
		dir_rows.push_back(pt_row(0, 1023, 0, 1'b0));
		dir_rows.push_back(pt_row(1023, 1023, 32767, 1'b0));
		dir_rows.push_back(pt_row(0, 0, -32768, 1'b0));
		dir_rows.push_back(pt_row(1, 1, -1, 1'b0));
		dir_rows.push_back(pt_row(1023, 1023, -32768, 1'b0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed list. Writes happen only once the block has handed back
		// every owed result.
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE) begin
				wait_drained();
				write_reg(row.reg_idx, row.data);
			end else begin
				send_point(row.pt, row.typed, row.res);
			end
		end

		// Random phases: two with a busy receiver, two with a lazy sender,
		// two with no idling at all.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			case (ph / 2)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_config();
			// The receiver holds off for a long stretch while points keep
			// coming, so the block fills and stalls its input.
			if (ph == 4)
				hold_req <= 1'b1;
			for (int n = 0; n < PHASE_POINTS; n++) begin
				// Halfway through one phase the sender stops until all
				// owed results are back, then resumes with the same bounds.
				if (ph == 2 && n == PHASE_POINTS / 2)
					wait_drained();
				p.col_index = pick_index();
				p.row_index = pick_index();
				case ($urandom_range(0, 5))
					0: p.height = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
					1: p.height = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
					2: p.height = HEIGHT_BITS'($urandom_range(0, 511) - 256);
					default: p.height = HEIGHT_BITS'($urandom);
				endcase
				p.first_point = ($urandom_range(0, 15) == 0);
				send_point(p, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (4 * LATENCY) @(posedge clk);

		$display("Covered %0d points (%0d bounds restarts, %0d saturated) over %0d setting phases",
			points_sent, restarts, sat_cnt, RAND_PHASES + 5);
		$display("Checked %0d results; input stalled %0d cycles under back-pressure",
			results_seen, stall_cycles);
		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ grid_point_projection_bounds.f @@
sv/gppb_pkg.sv
sv/gppb_front.sv
sv/gppb_queue.sv
sv/gppb_back.sv
sv/grid_point_projection_bounds.sv
dv/tb.sv
